### hw/rtl/qpr_pkg.sv
package qpr_pkg;

  localparam int POINT_W   = 24;
  localparam int QUAT_W    = 16;
  localparam int QFRAC     = QUAT_W - 2;
  localparam int OUT_SHIFT = 2 * QFRAC;

  // exact widths along the path
  localparam int PROD1_W = POINT_W + QUAT_W;   // quaternion times point
  localparam int T_W     = PROD1_W + 2;        // sum of three first products
  localparam int PROD2_W = T_W + QUAT_W;       // intermediate times quaternion
  localparam int R_W     = PROD2_W + 3;        // sum of four second products

  localparam logic signed [POINT_W-1:0] POINT_MAX = {1'b0, {(POINT_W-1){1'b1}}};
  localparam logic signed [POINT_W-1:0] POINT_MIN = {1'b1, {(POINT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic signed [POINT_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
    logic signed [QUAT_W-1:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [T_W-1:0] x;
    logic signed [T_W-1:0] y;
    logic signed [T_W-1:0] z;
    logic signed [T_W-1:0] w;
  } tvec_t;

  typedef struct packed {
    logic signed [R_W-1:0] x;
    logic signed [R_W-1:0] y;
    logic signed [R_W-1:0] z;
  } rvec_t;

endpackage

### hw/rtl/qpr_if.sv
interface qpr_in_if;
  import qpr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [POINT_W-1:0] point_x;
  logic signed [POINT_W-1:0] point_y;
  logic signed [POINT_W-1:0] point_z;
  logic signed [QUAT_W-1:0]  quat_x;
  logic signed [QUAT_W-1:0]  quat_y;
  logic signed [QUAT_W-1:0]  quat_z;
  logic signed [QUAT_W-1:0]  quat_w;

  modport source (output valid, point_x, point_y, point_z, quat_x, quat_y, quat_z, quat_w,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, quat_x, quat_y, quat_z, quat_w,
                output ready);
endinterface

interface qpr_out_if;
  import qpr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [POINT_W-1:0] rotated_x;
  logic signed [POINT_W-1:0] rotated_y;
  logic signed [POINT_W-1:0] rotated_z;
  logic                      saturated;

  modport source (output valid, rotated_x, rotated_y, rotated_z, saturated, input ready);
  modport sink (input valid, rotated_x, rotated_y, rotated_z, saturated, output ready);
endinterface

### hw/rtl/qpr_first.sv
// t = q * (p, 0): products in stage one, sums in stage two
module qpr_first (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  qpr_pkg::point_t in_point,
  input  qpr_pkg::quat_t  in_quat,
  output logic           t_valid,
  input  logic           t_ready,
  output qpr_pkg::tvec_t  t_vec,
  output qpr_pkg::quat_t  t_quat
);
  import qpr_pkg::*;

  logic signed [PROD1_W-1:0] m_nxt [12];
  logic signed [PROD1_W-1:0] m_r   [12];
  quat_t                     q1_r;
  quat_t                     q2_r;
  tvec_t                     t_nxt;
  tvec_t                     t_r;
  logic                      v1_r;
  logic                      v2_r;
  logic                      rdy1;
  logic                      rdy2;

  assign rdy2     = !v2_r || t_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    m_nxt[0]  = in_quat.w * in_point.x;
    m_nxt[1]  = in_quat.w * in_point.y;
    m_nxt[2]  = in_quat.w * in_point.z;
    m_nxt[3]  = in_quat.y * in_point.z;
    m_nxt[4]  = in_quat.z * in_point.y;
    m_nxt[5]  = in_quat.z * in_point.x;
    m_nxt[6]  = in_quat.x * in_point.z;
    m_nxt[7]  = in_quat.x * in_point.y;
    m_nxt[8]  = in_quat.y * in_point.x;
    m_nxt[9]  = in_quat.x * in_point.x;
    m_nxt[10] = in_quat.y * in_point.y;
    m_nxt[11] = in_quat.z * in_point.z;
  end

  always_comb begin
    t_nxt.x = T_W'(m_r[0]) + T_W'(m_r[3]) - T_W'(m_r[4]);
    t_nxt.y = T_W'(m_r[1]) + T_W'(m_r[5]) - T_W'(m_r[6]);
    t_nxt.z = T_W'(m_r[2]) + T_W'(m_r[7]) - T_W'(m_r[8]);
    t_nxt.w = -T_W'(m_r[9]) - T_W'(m_r[10]) - T_W'(m_r[11]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      m_r  <= m_nxt;
      q1_r <= in_quat;
    end
    if (rdy2 && v1_r) begin
      t_r  <= t_nxt;
      q2_r <= q1_r;
    end
  end

  assign t_valid = v2_r;
  assign t_vec   = t_r;
  assign t_quat  = q2_r;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !rdy2 |=> v1_r && $stable(q1_r))
    else $error("stage one item changed while stalled");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !t_ready |=> v2_r && $stable(t_r))
    else $error("stage two item changed while stalled");

endmodule

### hw/rtl/qpr_second.sv
// r = t * conj(q), vector part: products in stage three, sums in stage four
module qpr_second (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           t_valid,
  output logic           t_ready,
  input  qpr_pkg::tvec_t  t_vec,
  input  qpr_pkg::quat_t  t_quat,
  output logic           r_valid,
  input  logic           r_ready,
  output qpr_pkg::rvec_t  r_vec
);
  import qpr_pkg::*;

  logic signed [PROD2_W-1:0] m_nxt [12];
  logic signed [PROD2_W-1:0] m_r   [12];
  rvec_t                     r_nxt;
  rvec_t                     r_r;
  logic                      v3_r;
  logic                      v4_r;
  logic                      rdy3;
  logic                      rdy4;

  assign rdy4    = !v4_r || r_ready;
  assign rdy3    = !v3_r || rdy4;
  assign t_ready = rdy3;

  always_comb begin
    m_nxt[0]  = t_quat.w * t_vec.x;
    m_nxt[1]  = t_vec.w  * t_quat.x;
    m_nxt[2]  = t_vec.y  * t_quat.z;
    m_nxt[3]  = t_vec.z  * t_quat.y;
    m_nxt[4]  = t_quat.w * t_vec.y;
    m_nxt[5]  = t_vec.w  * t_quat.y;
    m_nxt[6]  = t_vec.z  * t_quat.x;
    m_nxt[7]  = t_vec.x  * t_quat.z;
    m_nxt[8]  = t_quat.w * t_vec.z;
    m_nxt[9]  = t_vec.w  * t_quat.z;
    m_nxt[10] = t_vec.x  * t_quat.y;
    m_nxt[11] = t_vec.y  * t_quat.x;
  end

  // conjugate signs folded into the adds
  always_comb begin
    r_nxt.x = R_W'(m_r[0]) - R_W'(m_r[1]) - R_W'(m_r[2])  + R_W'(m_r[3]);
    r_nxt.y = R_W'(m_r[4]) - R_W'(m_r[5]) - R_W'(m_r[6])  + R_W'(m_r[7]);
    r_nxt.z = R_W'(m_r[8]) - R_W'(m_r[9]) - R_W'(m_r[10]) + R_W'(m_r[11]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy3) v3_r <= t_valid;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && t_valid) m_r <= m_nxt;
    if (rdy4 && v3_r)    r_r <= r_nxt;
  end

  assign r_valid = v4_r;
  assign r_vec   = r_r;

  a_s4_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !r_ready |=> v4_r && $stable(r_r))
    else $error("stage four item changed while stalled");

endmodule

### hw/rtl/qpr_round.sv
// round half up, saturate to the point range, hold the result for the sink
module qpr_round (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           r_valid,
  output logic           r_ready,
  input  qpr_pkg::rvec_t  r_vec,
  output logic           out_valid,
  input  logic           out_ready,
  output qpr_pkg::point_t out_rot,
  output logic           out_sat
);
  import qpr_pkg::*;

  localparam int FL_W = R_W + 1 - OUT_SHIFT;

  typedef struct packed {
    logic                      sat;
    logic signed [POINT_W-1:0] val;
  } rs_t;

  function automatic rs_t round_sat(input logic signed [R_W-1:0] v);
    logic signed [R_W:0]    biased;
    logic signed [FL_W-1:0] fl;
    rs_t                    res;
    biased = (R_W+1)'(v) + ((R_W+1)'(1) << (OUT_SHIFT - 1));
    fl     = biased[R_W:OUT_SHIFT];
    if (fl > FL_W'(POINT_MAX)) begin
      res.sat = 1'b1;
      res.val = POINT_MAX;
    end else if (fl < FL_W'(POINT_MIN)) begin
      res.sat = 1'b1;
      res.val = POINT_MIN;
    end else begin
      res.sat = 1'b0;
      res.val = fl[POINT_W-1:0];
    end
    return res;
  endfunction

  rs_t    rx;
  rs_t    ry;
  rs_t    rz;
  point_t rot_r;
  logic   sat_r;
  logic   v_r;
  logic   rdy;

  assign rdy     = !v_r || out_ready;
  assign r_ready = rdy;

  always_comb begin
    rx = round_sat(r_vec.x);
    ry = round_sat(r_vec.y);
    rz = round_sat(r_vec.z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && r_valid) begin
      rot_r.x <= rx.val;
      rot_r.y <= ry.val;
      rot_r.z <= rz.val;
      sat_r   <= rx.sat | ry.sat | rz.sat;
    end
  end

  assign out_valid = v_r;
  assign out_rot   = rot_r;
  assign out_sat   = sat_r;

  a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && sat_r |-> rot_r.x == POINT_MAX || rot_r.x == POINT_MIN ||
                     rot_r.y == POINT_MAX || rot_r.y == POINT_MIN ||
                     rot_r.z == POINT_MAX || rot_r.z == POINT_MIN)
    else $error("saturation flagged with no component at a bound");

  a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
    r_valid && rdy |=> v_r)
    else $error("accepted item did not reach the output register");

endmodule

### hw/rtl/quaternion_point_rotation_core.sv
// Channel  | Direction | Handshake    | Payload
// in_ch    | sink      | valid/ready  | point_x/y/z (Q16.8), quat_x/y/z/w (Q1.14)
// out_ch   | source    | valid/ready  | rotated_x/y/z (Q16.8), saturated
//
// One item per clock sustained while out_ch.ready stays high; an accepted item reaches out_ch through the stages below.
// Five register stages: q*p products, t sums, t*conj(q) products, r sums, round/saturate.
// Each stage holds its own valid bit and takes a new item when empty or when the
// stage after it moves, so bubbles close up and a stall loses and repeats nothing.
// rst_n is synchronous, active low, and clears the valid bits only.
module quaternion_point_rotation_core (
  input  logic       clk,
  input  logic       rst_n,
  qpr_in_if.sink     in_ch,
  qpr_out_if.source  out_ch
);
  import qpr_pkg::*;

  point_t in_point;
  quat_t  in_quat;
  logic   t_valid;
  logic   t_ready;
  tvec_t  t_vec;
  quat_t  t_quat;
  logic   r_valid;
  logic   r_ready;
  rvec_t  r_vec;
  point_t out_rot;

  // pack the input fields
  assign in_point.x = in_ch.point_x;
  assign in_point.y = in_ch.point_y;
  assign in_point.z = in_ch.point_z;
  assign in_quat.x  = in_ch.quat_x;
  assign in_quat.y  = in_ch.quat_y;
  assign in_quat.z  = in_ch.quat_z;
  assign in_quat.w  = in_ch.quat_w;

  // first Hamilton product, kept exact
  qpr_first u_first (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_point (in_point),
    .in_quat  (in_quat),
    .t_valid  (t_valid),
    .t_ready  (t_ready),
    .t_vec    (t_vec),
    .t_quat   (t_quat)
  );

  // second product with the conjugate, vector part only, kept exact
  qpr_second u_second (
    .clk     (clk),
    .rst_n   (rst_n),
    .t_valid (t_valid),
    .t_ready (t_ready),
    .t_vec   (t_vec),
    .t_quat  (t_quat),
    .r_valid (r_valid),
    .r_ready (r_ready),
    .r_vec   (r_vec)
  );

  // drop the 2*QFRAC fraction bits with rounding, clip, and hold for the sink
  qpr_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .r_valid   (r_valid),
    .r_ready   (r_ready),
    .r_vec     (r_vec),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_rot   (out_rot),
    .out_sat   (out_ch.saturated)
  );

  assign out_ch.rotated_x = out_rot.x;
  assign out_ch.rotated_y = out_rot.y;
  assign out_ch.rotated_z = out_rot.z;

endmodule

### sim/tb_quaternion_point_rotation_core.sv
module tb_quaternion_point_rotation_core;
  timeunit 1ns;
  timeprecision 1ps;

  import qpr_pkg::*;

  // Generous bound: ~1300 items, each at worst a long send gap plus long
  // result stalls, taken several times over.
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAX_REPORTS = 10;
  // Pipeline depth from accept to result, plus margin for the tail.
  localparam int TAIL_CYCLES = 12;

  // One expected result: the rotated point and the clip flag.
  typedef struct packed {
    point_t pos;
    logic   sat;
  } rotation_t;

  logic clk = 1'b0;
  logic rst_n;

  qpr_in_if  in_ch();
  qpr_out_if out_ch();

  rotation_t   expected_rotations[$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on     = 1'b1;
  bit          stalls_on   = 1'b1;

  quaternion_point_rotation_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // Abort on a hang: a lost result or a stuck handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Round half toward plus infinity, then clip to the point range.
  function automatic logic signed [POINT_W-1:0] round_clip(input longint v, inout logic sat);
    longint r;
    r = (v + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (r > longint'(POINT_MAX)) begin
      sat = 1'b1;
      return POINT_MAX;
    end
    if (r < longint'(POINT_MIN)) begin
      sat = 1'b1;
      return POINT_MIN;
    end
    return r[POINT_W-1:0];
  endfunction

  // Exact q * (p, 0) * conj(q) in 64-bit integers; only the final vector
  // is rounded and clipped.
  function automatic rotation_t rotate_point(input point_t p, input quat_t q);
    longint px, py, pz, qx, qy, qz, qw;
    longint tx, ty, tz, tw, rx, ry, rz;
    rotation_t res;
    px = p.x; py = p.y; pz = p.z;
    qx = q.x; qy = q.y; qz = q.z; qw = q.w;
    // first product, q times the pure point
    tx = qw * px + (qy * pz - qz * py);
    ty = qw * py + (qz * px - qx * pz);
    tz = qw * pz + (qx * py - qy * px);
    tw = -(qx * px + qy * py + qz * pz);
    // second product with the conjugate; the real part is dropped
    rx = -tw * qx + qw * tx + (-ty * qz + tz * qy);
    ry = -tw * qy + qw * ty + (-tz * qx + tx * qz);
    rz = -tw * qz + qw * tz + (-tx * qy + ty * qx);
    res.sat   = 1'b0;
    res.pos.x = round_clip(rx, res.sat);
    res.pos.y = round_clip(ry, res.sat);
    res.pos.z = round_clip(rz, res.sat);
    return res;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result-side backpressure: bursts of ready, short and long stalls.
  initial begin
    int hold;
    bit rdy;
    hold = 0;
    rdy  = 1'b1;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        if (!stalls_on) begin
          rdy  = 1'b1;
          hold = 1;
        end else begin
          case ($urandom_range(0, 99)) inside
            [0:69]: begin
              rdy  = 1'b1;
              hold = $urandom_range(1, 6);
            end
            [70:93]: begin
              rdy  = 1'b0;
              hold = $urandom_range(1, 3);
            end
            default: begin
              rdy  = 1'b0;
              hold = $urandom_range(10, 40);
            end
          endcase
        end
      end
      out_ch.ready <= rdy;
      hold--;
    end
  end

  // Compare every accepted result against the oldest expectation.
  always @(posedge clk) begin
    rotation_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_rotations.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: x=%0d y=%0d z=%0d sat=%0b",
                   out_ch.rotated_x, out_ch.rotated_y, out_ch.rotated_z, out_ch.saturated);
      end else begin
        exp_r = expected_rotations.pop_front();
        if (out_ch.rotated_x !== exp_r.pos.x || out_ch.rotated_y !== exp_r.pos.y ||
            out_ch.rotated_z !== exp_r.pos.z || out_ch.saturated !== exp_r.sat) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: expected x=%0d y=%0d z=%0d sat=%0b, got x=%0d y=%0d z=%0d sat=%0b",
                     exp_r.pos.x, exp_r.pos.y, exp_r.pos.z, exp_r.sat,
                     out_ch.rotated_x, out_ch.rotated_y, out_ch.rotated_z,
                     out_ch.saturated);
        end
      end
    end
  end

  // Present one item at a falling edge and hold it until accepted. Valid
  // stays high on return when no gap follows, so the next item goes out
  // back to back.
  task automatic send_item(input point_t p, input quat_t q);
    int gap;
    in_ch.point_x <= p.x;
    in_ch.point_y <= p.y;
    in_ch.point_z <= p.z;
    in_ch.quat_x  <= q.x;
    in_ch.quat_y  <= q.y;
    in_ch.quat_z  <= q.z;
    in_ch.quat_w  <= q.w;
    in_ch.valid   <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_rotations.push_back(rotate_point(p, q));
    @(negedge clk);
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop valid and hold off until every outstanding result is back.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (expected_rotations.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic point_t make_point(input int x, input int y, input int z);
    point_t p;
    p.x = POINT_W'(x);
    p.y = POINT_W'(y);
    p.z = POINT_W'(z);
    return p;
  endfunction

  function automatic quat_t make_quat(input int x, input int y, input int z, input int w);
    quat_t q;
    q.x = QUAT_W'(x);
    q.y = QUAT_W'(y);
    q.z = QUAT_W'(z);
    q.w = QUAT_W'(w);
    return q;
  endfunction

  // Pick one coordinate: full 24-bit range, small, medium, or a boundary.
  function automatic logic signed [POINT_W-1:0] random_coord();
    case ($urandom_range(0, 3))
      0: return POINT_W'($urandom());
      1: return POINT_W'($urandom_range(0, 4095) - 2048);
      2: return POINT_W'($urandom_range(0, 2097151) - 1048576);
      default: begin
        case ($urandom_range(0, 4))
          0: return POINT_MAX;
          1: return POINT_MIN;
          2: return '0;
          3: return POINT_W'(1);
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // Mostly near-unit rotations; the rest scaled, raw bits, or boundaries.
  function automatic quat_t random_quat();
    real a, b, c, d, n, s;
    int  mode;
    quat_t q;
    mode = $urandom_range(0, 9);
    if (mode <= 5 || mode == 9) begin
      a = real'($urandom_range(0, 65535)) - 32768.0;
      b = real'($urandom_range(0, 65535)) - 32768.0;
      c = real'($urandom_range(0, 65535)) - 32768.0;
      d = real'($urandom_range(0, 65535)) - 32768.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) n = 1.0;
      s = 16384.0 / n;
      // non-unit: scale |q| between 0.25 and 1.99
      if (mode == 9) s = s * (0.25 + real'($urandom_range(0, 174)) / 100.0);
      q.x = QUAT_W'(int'(a * s));
      q.y = QUAT_W'(int'(b * s));
      q.z = QUAT_W'(int'(c * s));
      q.w = QUAT_W'(int'(d * s));
    end else if (mode <= 7) begin
      q = {$urandom(), $urandom()};
    end else begin
      q.x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      q.y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      q.z = $urandom_range(0, 2) == 0 ? 16'sh0000 : 16'sh8000;
      q.w = $urandom_range(0, 1) ? 16'sh4000 : 16'sh7fff;
    end
    return q;
  endfunction

  // Identity rotation passes the point through, boundaries included.
  task automatic test_identity();
    send_item(make_point(POINT_MAX, POINT_MIN, 0), make_quat(0, 0, 0, 16384));
    send_item(make_point(POINT_MIN, POINT_MAX, 1), make_quat(0, 0, 0, 16384));
    send_item(make_point(-1, 1, POINT_MAX), make_quat(0, 0, 0, 16384));
    send_item(make_point(0, 0, 0), make_quat(0, 0, 0, 16384));
    wait_for_results();
  endtask

  // Quarter and half turns, the axis-cycling turn, and -q giving the same turn.
  task automatic test_rotations();
    send_item(make_point(256, 512, -768), make_quat(0, 0, 11585, 11585));
    send_item(make_point(256, 512, -768), make_quat(0, 0, -11585, -11585));
    send_item(make_point(1000, -2000, 3000), make_quat(16384, 0, 0, 0));
    send_item(make_point(1000, -2000, 3000), make_quat(8192, 8192, 8192, 8192));
    send_item(make_point(POINT_MAX, POINT_MIN, POINT_MAX), make_quat(0, 16384, 0, 0));
    wait_for_results();
  endtask

  // With w = 0.5 the point is scaled by a quarter: exact halves show
  // rounding toward plus infinity on both signs.
  task automatic test_rounding();
    send_item(make_point(2, -2, 6), make_quat(0, 0, 0, 8192));
    send_item(make_point(-6, 1, 3), make_quat(0, 0, 0, 8192));
    send_item(make_point(-1, 5, -3), make_quat(0, 0, 0, -8192));
    wait_for_results();
  endtask

  // Non-unit quaternions: zero, scale right at the clip bound, and the
  // component extremes driving both ends into saturation.
  task automatic test_scaling();
    send_item(make_point(POINT_MAX, POINT_MIN, 77), make_quat(0, 0, 0, 0));
    send_item(make_point(2097152, -2097152, 5), make_quat(0, 0, 0, -32768));
    send_item(make_point(2097151, -2097152, -5), make_quat(0, 0, 0, -32768));
    send_item(make_point(POINT_MAX, POINT_MAX, POINT_MAX),
              make_quat(32767, 32767, 32767, 32767));
    send_item(make_point(POINT_MIN, POINT_MIN, POINT_MIN),
              make_quat(-32768, -32768, -32768, -32768));
    send_item(make_point(POINT_MAX, POINT_MIN, POINT_MAX),
              make_quat(32767, -32768, 0, 32767));
    send_item(make_point(1, -1, 1), make_quat(-32768, 32767, -32768, -32768));
    wait_for_results();
  endtask

  // Random stream in chunks, each with its own idling mix; pause once
  // midway until the pipeline drains.
  task automatic test_random_stream();
    point_t p;
    quat_t  q;
    for (int chunk = 0; chunk < 10; chunk++) begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 125; n++) begin
        p.x = random_coord();
        p.y = random_coord();
        p.z = random_coord();
        q = random_quat();
        send_item(p, q);
      end
      if (chunk == 4) wait_for_results();
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    wait_for_results();
  endtask

  initial begin
    // Drive every input to a known value before the first edge.
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    in_ch.quat_x  = '0;
    in_ch.quat_y  = '0;
    in_ch.quat_z  = '0;
    in_ch.quat_w  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_identity();
    test_rotations();
    test_rounding();
    test_scaling();
    test_random_stream();

    // Let the tail settle so a stray extra result is caught.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_rotations.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
